[sv/rts_pkg.sv]
// Shared types, constants and helpers for the ring task scheduler.
package rts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int COUNT_W    = $clog2(TASK_SLOTS + 1);
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SCHED  = 2'd2,
    MODE_SETRUN = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_LAST   = 3'd2,
    ST_UNUSED = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_LINK,
    S_REM_LINK,
    S_WALK_RD,
    S_WALK
  } state_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_pick_t;

  // Lowest slot whose used bit is clear.
  function automatic free_pick_t first_free(input logic [TASK_SLOTS-1:0] used);
    free_pick_t pick;
    pick.found = 1'b0;
    pick.slot  = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        pick.found = 1'b1;
        pick.slot  = SLOT_W'(i);
      end
    end
    return pick;
  endfunction

endpackage

[sv/rts_link_ram.sv]
// Single-port-write, single-port-read link memory with registered read data.
module rts_link_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ring_task_scheduler_unit.sv]
// Round-robin task scheduler over a circular doubly linked ring of task slots.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+---------------------------
//   command  | mode, task_slot, run_flag          | start & !busy
//   result   | status, result_slot, switched      | done, one cycle, no stall
//
// Set running, and any command refused as soon as it is accepted, ends on acceptance.
// Add ends on acceptance on an empty ring, else it goes on to S_ADD_LINK (one link read).
// Schedule walks the ring with one next-link read per slot visited in the
// walk. Remove goes to S_REM_LINK, then to S_WALK_RD and a walk if it removes the current task.
// Reset clears all slot flags, the count and current slot at once; the link
// memories need no clearing. The result strobe is never held off.
module ring_task_scheduler_unit
  import rts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [SLOT_W-1:0]   task_slot,
  input  logic                run_flag,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   result_slot,
  output logic                switched
);

  localparam logic [SLOT_W-1:0] WALK_LAST = SLOT_W'(TASK_SLOTS - 1);

  state_t state, state_next;

  logic [TASK_SLOTS-1:0] slot_used, slot_used_next;
  logic [TASK_SLOTS-1:0] slot_running, slot_running_next;
  logic [SLOT_W-1:0]     current_slot, current_slot_next;
  logic [COUNT_W-1:0]    task_count, task_count_next;
  logic [SLOT_W-1:0]     op_slot;
  logic [SLOT_W-1:0]     start_slot;
  logic [SLOT_W-1:0]     new_slot;
  logic [SLOT_W-1:0]     walk_cnt, walk_cnt_next;

  logic              next_we, prev_we;
  logic [SLOT_W-1:0] next_waddr, next_wdata, next_raddr, next_q;
  logic [SLOT_W-1:0] prev_waddr, prev_wdata, prev_raddr, prev_q;

  logic              res_valid;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_sw;

  logic       accept;
  free_pick_t pick;
  logic       walk_hit;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign pick     = first_free(slot_used);
  assign walk_hit = slot_used[next_q] && slot_running[next_q];

  rts_link_ram #(.DEPTH(TASK_SLOTS), .WIDTH(SLOT_W)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_q)
  );

  rts_link_ram #(.DEPTH(TASK_SLOTS), .WIDTH(SLOT_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_ADD: begin
              if (pick.found && task_count != '0) begin
                state_next = S_ADD_LINK;
              end
            end
            MODE_REMOVE: begin
              if (slot_used[task_slot] && task_count > COUNT_W'(1)) begin
                state_next = S_REM_LINK;
              end
            end
            MODE_SCHED: begin
              if (task_count != '0) begin
                state_next = S_WALK;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_LINK: state_next = S_IDLE;
      S_REM_LINK: state_next = (op_slot == current_slot) ? S_WALK_RD : S_IDLE;
      S_WALK_RD:  state_next = S_WALK;
      S_WALK: begin
        if (walk_hit || walk_cnt == WALK_LAST) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory accesses, state updates and the result of each transaction.
  always_comb begin
    slot_used_next    = slot_used;
    slot_running_next = slot_running;
    current_slot_next = current_slot;
    task_count_next   = task_count;
    walk_cnt_next     = '0;
    next_we    = 1'b0;
    next_waddr = current_slot;
    next_wdata = current_slot;
    next_raddr = current_slot;
    prev_we    = 1'b0;
    prev_waddr = current_slot;
    prev_wdata = current_slot;
    prev_raddr = task_slot;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_slot   = current_slot;
    res_sw     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_ADD: begin
              if (!pick.found) begin
                res_valid  = 1'b1;
                res_status = ST_FULL;
              end else begin
                slot_used_next[pick.slot]    = 1'b1;
                slot_running_next[pick.slot] = 1'b0;
                task_count_next = task_count + COUNT_W'(1);
                if (task_count == '0) begin
                  // First task links to itself and becomes current.
                  next_we           = 1'b1;
                  next_waddr        = pick.slot;
                  next_wdata        = pick.slot;
                  prev_we           = 1'b1;
                  prev_waddr        = pick.slot;
                  prev_wdata        = pick.slot;
                  current_slot_next = pick.slot;
                  res_valid         = 1'b1;
                  res_slot          = pick.slot;
                  res_sw            = 1'b1;
                end else begin
                  // The read of next[current] sees the link before this write.
                  next_we    = 1'b1;
                  next_waddr = current_slot;
                  next_wdata = pick.slot;
                  prev_we    = 1'b1;
                  prev_waddr = pick.slot;
                  prev_wdata = current_slot;
                  next_raddr = current_slot;
                end
              end
            end
            MODE_REMOVE: begin
              if (!slot_used[task_slot]) begin
                res_valid  = 1'b1;
                res_status = ST_UNUSED;
              end else if (task_count <= COUNT_W'(1)) begin
                res_valid  = 1'b1;
                res_status = ST_LAST;
              end else begin
                next_raddr = task_slot;
                prev_raddr = task_slot;
              end
            end
            MODE_SCHED: begin
              if (task_count == '0) begin
                res_valid  = 1'b1;
                res_status = ST_NONE;
              end else begin
                next_raddr = current_slot;
              end
            end
            MODE_SETRUN: begin
              res_valid = 1'b1;
              if (!slot_used[task_slot]) begin
                res_status = ST_UNUSED;
              end else begin
                slot_running_next[task_slot] = run_flag;
              end
            end
            default: res_valid = 1'b0;
          endcase
        end
      end
      S_ADD_LINK: begin
        next_we    = 1'b1;
        next_waddr = new_slot;
        next_wdata = next_q;
        prev_we    = 1'b1;
        prev_waddr = next_q;
        prev_wdata = new_slot;
        res_valid  = 1'b1;
        res_slot   = new_slot;
      end
      S_REM_LINK: begin
        next_we    = 1'b1;
        next_waddr = prev_q;
        next_wdata = next_q;
        prev_we    = 1'b1;
        prev_waddr = next_q;
        prev_wdata = prev_q;
        slot_used_next[op_slot]    = 1'b0;
        slot_running_next[op_slot] = 1'b0;
        task_count_next = task_count - COUNT_W'(1);
        if (op_slot == current_slot) begin
          current_slot_next = prev_q;
        end else begin
          res_valid = 1'b1;
        end
      end
      S_WALK_RD: begin
        // The unlink has landed, so next[current] now skips the removed slot.
        next_raddr = current_slot;
      end
      S_WALK: begin
        if (walk_hit) begin
          current_slot_next = next_q;
          res_valid         = 1'b1;
          res_slot          = next_q;
          res_sw            = (next_q != start_slot);
        end else if (walk_cnt == WALK_LAST) begin
          res_valid  = 1'b1;
          res_status = ST_NONE;
          res_sw     = (current_slot != start_slot);
        end else begin
          next_raddr    = next_q;
          walk_cnt_next = walk_cnt + SLOT_W'(1);
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_used    <= '0;
      slot_running <= '0;
      current_slot <= '0;
      task_count   <= '0;
      walk_cnt     <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      slot_used    <= slot_used_next;
      slot_running <= slot_running_next;
      current_slot <= current_slot_next;
      task_count   <= task_count_next;
      walk_cnt     <= walk_cnt_next;
      done         <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_slot    <= task_slot;
      start_slot <= current_slot;
      new_slot   <= pick.slot;
    end
    if (res_valid) begin
      status      <= res_status;
      result_slot <= res_slot;
      switched    <= res_sw;
    end
  end

  // The count always matches the number of slots in use.
  assert property (@(posedge clk) disable iff (rst)
    $countones(slot_used) == int'(task_count))
    else $error("task count differs from number of used slots");

  // Only slots in use can be marked running.
  assert property (@(posedge clk) disable iff (rst)
    (slot_running & ~slot_used) == '0)
    else $error("running flag set on a free slot");

  // While any task exists, the current slot is one of them.
  assert property (@(posedge clk) disable iff (rst)
    task_count != '0 |-> slot_used[current_slot])
    else $error("current slot is not in use");

  // A transaction that leaves idle raises the result strobe on its return to idle.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && (state_next == S_IDLE) |=> done)
    else $error("command finished without a result strobe");

endmodule
